### hdl/ifd_pkg.sv
// ============================================================================
// ifd_pkg
// Shared types, constants and helper functions for the integer floor divider.
// ============================================================================
package ifd_pkg;

    // Widest element the datapath supports by default.
    localparam int DEFAULT_MAX_WIDTH = 64;

    // Width of the operand and quotient ports.
    localparam int PORT_WIDTH = 64;

    // Width of the element type register.
    localparam int ETYPE_WIDTH = 3;

    // Element type codes held in the configuration register.
    typedef enum logic [ETYPE_WIDTH-1:0] {
        ET_UINT8  = 3'd0,
        ET_INT8   = 3'd1,
        ET_UINT16 = 3'd2,
        ET_INT16  = 3'd3,
        ET_INT32  = 3'd4,
        ET_INT64  = 3'd5
    } etype_t;

    // Element format derived from the type register: width in bits and signedness.
    typedef struct packed {
        logic [6:0] width;
        logic       sgn;
    } ifd_fmt_t;

    // Per-item control bits carried alongside the datapath.
    typedef struct packed {
        logic neg;
        logic dz;
        logic last;
    } ifd_ctl_t;

    // Element width in bits for a type code; unused codes act as 64-bit.
    function automatic logic [6:0] type_width(input logic [ETYPE_WIDTH-1:0] code);
        logic [6:0] w;
        case (code)
            ET_UINT8:  w = 7'd8;
            ET_INT8:   w = 7'd8;
            ET_UINT16: w = 7'd16;
            ET_INT16:  w = 7'd16;
            ET_INT32:  w = 7'd32;
            ET_INT64:  w = 7'd64;
            default:   w = 7'd64;
        endcase
        return w;
    endfunction

    // Signedness for a type code; unused codes act as signed.
    function automatic logic type_signed(input logic [ETYPE_WIDTH-1:0] code);
        logic s;
        case (code)
            ET_UINT8:  s = 1'b0;
            ET_UINT16: s = 1'b0;
            default:   s = 1'b1;
        endcase
        return s;
    endfunction

    // Keep the low w bits of v, then sign- or zero-extend them to the full word.
    function automatic logic [PORT_WIDTH-1:0] narrow(input logic [PORT_WIDTH-1:0] v,
                                                     input ifd_fmt_t fmt);
        logic [PORT_WIDTH-1:0] mask;
        logic [5:0]            msb_idx;
        logic [PORT_WIDTH-1:0] r;
        if (fmt.width >= 7'(PORT_WIDTH))
            mask = '1;
        else
            mask = (64'd1 << fmt.width) - 64'd1;
        msb_idx = 6'(fmt.width - 7'd1);
        r = v & mask;
        if (fmt.sgn && v[msb_idx])
            r = r | ~mask;
        return r;
    endfunction

endpackage

### hdl/integer_floor_divider.sv
// Pipeline: one input stage, one restoring step per quotient bit, one output stage.
// Throughput: one element pair per cycle; the whole pipeline holds while the
// output register is full and not taken.
// Reset: asynchronous, active low; clears all valid bits and sets the element
// type to int32.
// ============================================================================
// integer_floor_divider
// Pipelined element-wise floor divider for signed 8/16/32/64-bit and unsigned
// 8/16-bit integer elements, with divide-by-zero flag and last-element pass-through.
// ============================================================================
module integer_floor_divider #(
    parameter int MAX_WIDTH = ifd_pkg::DEFAULT_MAX_WIDTH
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write_en,
    input  logic [ifd_pkg::ETYPE_WIDTH-1:0]      cfg_write_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [ifd_pkg::PORT_WIDTH-1:0]       dividend,
    input  logic [ifd_pkg::PORT_WIDTH-1:0]       divisor,
    input  logic                                 last_element,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [ifd_pkg::PORT_WIDTH-1:0]       quotient,
    output logic                                 divide_by_zero,
    output logic                                 last_out
);
    import ifd_pkg::*;

    logic [ETYPE_WIDTH-1:0] etype_reg;
    logic [6:0]             type_w;
    ifd_fmt_t               fmt;
    logic                   advance;

    logic                   valid_s [MAX_WIDTH+1];
    ifd_ctl_t               ctl_s   [MAX_WIDTH+1];
    logic [MAX_WIDTH-1:0]   rem_s   [MAX_WIDTH+1];
    logic [MAX_WIDTH-1:0]   dq_s    [MAX_WIDTH+1];
    logic [MAX_WIDTH-1:0]   ay_s    [MAX_WIDTH+1];

    // Element type register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            etype_reg <= ET_INT32;
        else if (cfg_write_en)
            etype_reg <= cfg_write_data;
    end

    // Element format, with the width capped at the datapath width.
    always_comb
    begin
        type_w = type_width(etype_reg);
        fmt.sgn = type_signed(etype_reg);
        if (type_w > 7'(MAX_WIDTH))
            fmt.width = 7'(MAX_WIDTH);
        else
            fmt.width = type_w;
    end

    // The pipeline moves whenever the output register is empty or being taken.
    assign advance  = !out_valid || out_ready;
    assign in_ready = advance;

    // Input stage.
    ifd_prep #(
        .DATA_WIDTH (MAX_WIDTH)
    ) u_prep (
        .clk          (clk),
        .rst_n        (rst_n),
        .enable       (advance),
        .fmt          (fmt),
        .in_valid     (in_valid),
        .dividend     (dividend),
        .divisor      (divisor),
        .last_element (last_element),
        .valid_out    (valid_s[0]),
        .ctl_out      (ctl_s[0]),
        .dq_out       (dq_s[0]),
        .ay_out       (ay_s[0])
    );

    assign rem_s[0] = '0;

    // One restoring step per quotient bit.
    for (genvar i = 0; i < MAX_WIDTH; i++)
    begin : g_step
        ifd_div_stage #(
            .DATA_WIDTH (MAX_WIDTH)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .enable    (advance),
            .valid_in  (valid_s[i]),
            .ctl_in    (ctl_s[i]),
            .rem_in    (rem_s[i]),
            .dq_in     (dq_s[i]),
            .ay_in     (ay_s[i]),
            .valid_out (valid_s[i+1]),
            .ctl_out   (ctl_s[i+1]),
            .rem_out   (rem_s[i+1]),
            .dq_out    (dq_s[i+1]),
            .ay_out    (ay_s[i+1])
        );
    end

    // Output stage.
    ifd_post #(
        .DATA_WIDTH (MAX_WIDTH)
    ) u_post (
        .clk            (clk),
        .rst_n          (rst_n),
        .enable         (advance),
        .fmt            (fmt),
        .valid_in       (valid_s[MAX_WIDTH]),
        .ctl_in         (ctl_s[MAX_WIDTH]),
        .q_in           (dq_s[MAX_WIDTH]),
        .r_in           (rem_s[MAX_WIDTH]),
        .out_valid      (out_valid),
        .quotient       (quotient),
        .divide_by_zero (divide_by_zero),
        .last_out       (last_out)
    );

endmodule

### hdl/ifd_prep.sv
// ============================================================================
// ifd_prep
// Input stage: narrows both operands to the element format, takes their
// magnitudes and flags a zero divisor.
// ============================================================================
module ifd_prep #(
    parameter int DATA_WIDTH = ifd_pkg::DEFAULT_MAX_WIDTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              enable,
    input  ifd_pkg::ifd_fmt_t                 fmt,
    input  logic                              in_valid,
    input  logic [ifd_pkg::PORT_WIDTH-1:0]    dividend,
    input  logic [ifd_pkg::PORT_WIDTH-1:0]    divisor,
    input  logic                              last_element,
    output logic                              valid_out,
    output ifd_pkg::ifd_ctl_t                 ctl_out,
    output logic [DATA_WIDTH-1:0]             dq_out,
    output logic [DATA_WIDTH-1:0]             ay_out
);
    import ifd_pkg::*;

    logic [PORT_WIDTH-1:0] x;
    logic [PORT_WIDTH-1:0] y;
    logic                  nx;
    logic                  ny;
    logic [DATA_WIDTH-1:0] ax_next;
    logic [DATA_WIDTH-1:0] ay_next;
    ifd_ctl_t              ctl_next;

    logic                  valid_reg;
    ifd_ctl_t              ctl_reg;
    logic [DATA_WIDTH-1:0] ax_reg;
    logic [DATA_WIDTH-1:0] ay_reg;

    // Narrow the operands and form their magnitudes.
    always_comb
    begin
        x = narrow(dividend, fmt);
        y = narrow(divisor, fmt);
        nx = fmt.sgn && x[PORT_WIDTH-1];
        ny = fmt.sgn && y[PORT_WIDTH-1];
        ax_next = nx ? (DATA_WIDTH'(0) - x[DATA_WIDTH-1:0]) : x[DATA_WIDTH-1:0];
        ay_next = ny ? (DATA_WIDTH'(0) - y[DATA_WIDTH-1:0]) : y[DATA_WIDTH-1:0];
        ctl_next.neg  = nx ^ ny;
        ctl_next.dz   = (y == '0);
        ctl_next.last = last_element;
    end

    // Valid bit for this stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (enable)
            valid_reg <= in_valid;
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (enable)
        begin
            ctl_reg <= ctl_next;
            ax_reg  <= ax_next;
            ay_reg  <= ay_next;
        end
    end

    assign valid_out = valid_reg;
    assign ctl_out   = ctl_reg;
    assign dq_out    = ax_reg;
    assign ay_out    = ay_reg;

endmodule

### hdl/ifd_div_stage.sv
// ============================================================================
// ifd_div_stage
// One restoring division step: shifts in one dividend bit, trial-subtracts
// the divisor and produces one quotient bit.
// ============================================================================
module ifd_div_stage #(
    parameter int DATA_WIDTH = ifd_pkg::DEFAULT_MAX_WIDTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  enable,
    input  logic                  valid_in,
    input  ifd_pkg::ifd_ctl_t     ctl_in,
    input  logic [DATA_WIDTH-1:0] rem_in,
    input  logic [DATA_WIDTH-1:0] dq_in,
    input  logic [DATA_WIDTH-1:0] ay_in,
    output logic                  valid_out,
    output ifd_pkg::ifd_ctl_t     ctl_out,
    output logic [DATA_WIDTH-1:0] rem_out,
    output logic [DATA_WIDTH-1:0] dq_out,
    output logic [DATA_WIDTH-1:0] ay_out
);
    import ifd_pkg::*;

    logic [DATA_WIDTH:0]   trial;
    logic [DATA_WIDTH:0]   diff;
    logic                  fits;
    logic [DATA_WIDTH-1:0] rem_next;
    logic [DATA_WIDTH-1:0] dq_next;

    logic                  valid_reg;
    ifd_ctl_t              ctl_reg;
    logic [DATA_WIDTH-1:0] rem_reg;
    logic [DATA_WIDTH-1:0] dq_reg;
    logic [DATA_WIDTH-1:0] ay_reg;

    // Trial subtraction; the remainder stays below the divisor, so it fits.
    always_comb
    begin
        trial    = {rem_in, dq_in[DATA_WIDTH-1]};
        diff     = trial - {1'b0, ay_in};
        fits     = (trial >= {1'b0, ay_in});
        rem_next = fits ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
        dq_next  = {dq_in[DATA_WIDTH-2:0], fits};
    end

    // Valid bit for this stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (enable)
            valid_reg <= valid_in;
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (enable)
        begin
            ctl_reg <= ctl_in;
            rem_reg <= rem_next;
            dq_reg  <= dq_next;
            ay_reg  <= ay_in;
        end
    end

    assign valid_out = valid_reg;
    assign ctl_out   = ctl_reg;
    assign rem_out   = rem_reg;
    assign dq_out    = dq_reg;
    assign ay_out    = ay_reg;

endmodule

### hdl/ifd_post.sv
// ============================================================================
// ifd_post
// Output stage: applies the floor correction and sign, wraps the quotient to
// the element format and holds the result for the output transfer.
// ============================================================================
module ifd_post #(
    parameter int DATA_WIDTH = ifd_pkg::DEFAULT_MAX_WIDTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              enable,
    input  ifd_pkg::ifd_fmt_t                 fmt,
    input  logic                              valid_in,
    input  ifd_pkg::ifd_ctl_t                 ctl_in,
    input  logic [DATA_WIDTH-1:0]             q_in,
    input  logic [DATA_WIDTH-1:0]             r_in,
    output logic                              out_valid,
    output logic [ifd_pkg::PORT_WIDTH-1:0]    quotient,
    output logic                              divide_by_zero,
    output logic                              last_out
);
    import ifd_pkg::*;

    logic                  round_up;
    logic [DATA_WIDTH-1:0] q_inv;
    logic [DATA_WIDTH-1:0] res;
    logic [PORT_WIDTH-1:0] quotient_next;

    logic                  valid_reg;
    logic [PORT_WIDTH-1:0] quotient_reg;
    logic                  dz_reg;
    logic                  last_reg;

    // Mixed signs: -(q + round_up) equals ~q when rounding up, ~q + 1 otherwise.
    always_comb
    begin
        round_up = (r_in != '0);
        q_inv    = ~q_in;
        if (ctl_in.neg)
            res = round_up ? q_inv : (q_inv + DATA_WIDTH'(1));
        else
            res = q_in;
        if (ctl_in.dz)
            quotient_next = '0;
        else
            quotient_next = narrow(PORT_WIDTH'(res), fmt);
    end

    // Output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (enable)
            valid_reg <= valid_in;
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (enable)
        begin
            quotient_reg <= quotient_next;
            dz_reg       <= ctl_in.dz;
            last_reg     <= ctl_in.last;
        end
    end

    assign out_valid      = valid_reg;
    assign quotient       = quotient_reg;
    assign divide_by_zero = dz_reg;
    assign last_out       = last_reg;

endmodule
